// File: rtl/grid_raycast_column_top_macros.svh
// Assertion helpers for the ray caster; all are clocked on clock and
// disabled while reset is high.
`ifndef GRID_RAYCAST_COLUMN_TOP_MACROS_SVH
`define GRID_RAYCAST_COLUMN_TOP_MACROS_SVH

// Same-cycle implication.
`define GRC_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define GRC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/grc_pkg.sv
package grc_pkg;

   // Grid and angle geometry
   localparam int GRID_CELLS  = 64;
   localparam int CELL_SHIFT  = 6;
   localparam int CELL_W      = $clog2(GRID_CELLS);
   localparam int COORD_W     = CELL_W + 1;
   localparam int CELL_SPAN   = 1 << CELL_SHIFT;
   localparam int MAP_SIZE    = GRID_CELLS * GRID_CELLS;
   localparam int MAP_W       = 2 * CELL_W;
   localparam int ANGLE_STEPS = 4096;
   localparam int ANGLE_W     = $clog2(ANGLE_STEPS);
   localparam int QUARTER     = ANGLE_STEPS / 4;
   localparam int QIDX_W      = $clog2(QUARTER) + 1;
   localparam int SCREEN_ROWS = 200;
   localparam int HALF_ROWS   = SCREEN_ROWS / 2;
   localparam int H_MAX       = 2 * SCREEN_ROWS;
   localparam int H_W         = $clog2(H_MAX + 1);

   // Field widths
   localparam int OP_W    = 1;
   localparam int INDEX_W = 12;
   localparam int VALUE_W = 16;
   localparam int POS_W   = 12;
   localparam int COL_W   = 9;
   localparam int ROW_W   = 8;

   // Arithmetic widths
   localparam int TRIG_W = 15;
   localparam int DIST_W = 32;
   localparam int NUM_W  = 37;
   localparam int DCNT_W = $clog2(NUM_W);
   localparam int OFF_W  = CELL_SHIFT + 1;
   localparam int PROD_W = DIST_W + TRIG_W;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;
   localparam int FOV_W      = 11;
   localparam int ASTEP_W    = 8;
   localparam int PDIST_W    = 10;
   localparam logic [FOV_W-1:0]   HALF_FOV_RST   = FOV_W'(320);
   localparam logic [ASTEP_W-1:0] ANGLE_STEP_RST = ASTEP_W'(2);
   localparam logic [PDIST_W-1:0] PLANE_DIST_RST = PDIST_W'(277);

   localparam logic [CSR_IDX_W-1:0] CSR_HALF_FOV   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_STEP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_DIST = 2'd2;

   localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
   localparam logic [OP_W-1:0] OP_CAST  = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_TRIG_C, ST_TRIG_S, ST_TRIG_R, ST_SETUP,
      ST_DIV_LOAD, ST_DIV_RUN, ST_DIV_STORE, ST_WALK, ST_WALK_CHK,
      ST_MULT, ST_CORR, ST_HEIGHT, ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      DIV_DX, DIV_DELX, DIV_DY, DIV_DELY, DIV_H
   } div_sel_type;

   typedef logic [TRIG_W-1:0] sin_rom_type [0:QUARTER];

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   // Quarter-wave sine in unsigned Q1.14 from the odd series to the ninth power
   function automatic logic [TRIG_W-1:0] sin_quarter(input int unsigned q);
      longint unsigned p;
      longint unsigned r;
      longint unsigned r2;
      longint unsigned term;
      longint          sum;
      p    = longint'(q) << (32 - ANGLE_W);
      r    = (p * HALF_PI_Q30) >> 30;
      r2   = (r * r) >> 30;
      term = r;
      sum  = longint'(r);
      term = ((term * r2) >> 30) / 6;
      sum  = sum - longint'(term);
      term = ((term * r2) >> 30) / 20;
      sum  = sum + longint'(term);
      term = ((term * r2) >> 30) / 42;
      sum  = sum - longint'(term);
      term = ((term * r2) >> 30) / 72;
      sum  = sum + longint'(term);
      if (sum < 0) sum = 0;
      sum = (sum + 32768) >>> 16;
      if (sum > 16384) sum = 16384;
      return TRIG_W'(sum);
   endfunction

   function automatic sin_rom_type build_sin_rom();
      sin_rom_type t;
      for (int i = 0; i <= QUARTER; i++) begin
         t[i] = sin_quarter(i);
      end
      return t;
   endfunction

endpackage

// File: rtl/grc_req_if.sv
interface grc_req_if import grc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    operation;
   logic [INDEX_W-1:0] cell_index;
   logic [VALUE_W-1:0] cell_value;
   logic [POS_W-1:0]   view_x;
   logic [POS_W-1:0]   view_y;
   logic [ANGLE_W-1:0] view_angle;
   logic [COL_W-1:0]   column;

   modport source (output valid, operation, cell_index, cell_value, view_x, view_y,
                   view_angle, column, input ready);
   modport sink (input valid, operation, cell_index, cell_value, view_x, view_y,
                 view_angle, column, output ready);
endinterface

// File: rtl/grc_rsp_if.sv
interface grc_rsp_if import grc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [COL_W-1:0] out_column;
   logic [ROW_W-1:0] wall_top;
   logic [ROW_W-1:0] wall_bottom;
   logic             wall_hit;
   logic             hit_side;

   modport source (output valid, out_column, wall_top, wall_bottom, wall_hit, hit_side,
                   input ready);
   modport sink (input valid, out_column, wall_top, wall_bottom, wall_hit, hit_side,
                 output ready);
endinterface

// File: rtl/grid_raycast_column_top.sv
// Column ray caster over a 64 x 64 grid of wall flags.
// req_ch carries two kinds of item. A map write (operation 0) sets one cell to
// wall when cell_value is nonzero and clears it otherwise, and gives no
// result. A cast (operation 1) gives a view position, heading and screen
// column and yields one rsp_ch item with the wall rows of that column.
// csr_we/csr_index/csr_wdata write half_fov, angle_step and plane_distance;
// write them only while no cast is in flight.
// A cast takes three sine table reads, four divisions (load, 37 restoring
// steps, store) for the boundary distances (skipped on an axis ray), a walk
// step and a map check per grid cell crossed, a multiply and one more
// division for the wall height. One serial restoring divider serves every
// division, and the map has a single read port.
// req_ch.ready is high only between casts; a finished result sits in the
// output register and the next item is accepted while it waits. If rsp_ch is
// stalled when a second cast completes, the block holds until it drains.
// After reset the map is swept clear one cell a cycle with req_ch.ready
// low; configuration writes are taken throughout.
module grid_raycast_column_top import grc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   grc_req_if.sink               req_ch,
   grc_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam sin_rom_type SIN_ROM = build_sin_rom();
   localparam logic [DIST_W:0]   DIST_INF = {1'b1, {DIST_W{1'b0}}};
   localparam logic [DIST_W-1:0] DIST_SAT = {DIST_W{1'b1}};

   state_type state_ff, state_in;
   div_sel_type sel_ff, sel_in;

   logic [FOV_W-1:0]   half_fov_ff;
   logic [ASTEP_W-1:0] angle_step_ff;
   logic [PDIST_W-1:0] plane_dist_ff;

   logic [MAP_W-1:0]   clr_addr_ff, clr_addr_in;
   logic               map_mem [MAP_SIZE];
   logic               map_q_ff;
   logic               map_we;
   logic [MAP_W-1:0]   map_waddr, map_raddr;
   logic               map_wdata;

   logic [ANGLE_W-1:0] rom_ang;
   logic [QIDX_W-1:0]  rom_idx;
   logic [TRIG_W-1:0]  rom_q_ff;
   logic               rom_neg_ff;

   logic [COL_W-1:0]   col_ff, col_in;
   logic [ANGLE_W-1:0] ray_ff, ray_in, rel_ff, rel_in;
   logic [COORD_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [CELL_SHIFT-1:0] vxo_ff, vxo_in, vyo_ff, vyo_in;
   logic [TRIG_W-1:0]  cmag_ff, cmag_in, smag_ff, smag_in, rmag_ff, rmag_in;
   logic               cneg_ff, cneg_in, sneg_ff, sneg_in, rneg_ff, rneg_in;
   logic [OFF_W-1:0]   offx_ff, offx_in, offy_ff, offy_in;
   logic               xdec_ff, xdec_in, ydec_ff, ydec_in;
   logic [DIST_W:0]    dx_ff, dx_in, dy_ff, dy_in;
   logic [DIST_W-1:0]  delx_ff, delx_in, dely_ff, dely_in;
   logic [DIST_W-1:0]  dist_ff, dist_in, corr_ff, corr_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [H_W-1:0]     h_ff, h_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [DIST_W-1:0]  den_ff, den_in;
   logic [DIST_W:0]    rem_ff, rem_in;
   logic [DCNT_W-1:0]  cnt_ff, cnt_in;
   logic [ROW_W-1:0]   top_ff, top_in, bot_ff, bot_in;
   logic               hit_ff, hit_in, side_ff, side_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]   rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]   rsp_top_ff, rsp_top_in, rsp_bot_ff, rsp_bot_in;
   logic               rsp_hit_ff, rsp_hit_in, rsp_side_ff, rsp_side_in;

   logic               req_fire, in_grid, c_pos, s_pos, x_step, out_ok;
   logic [COORD_W-1:0] ncx, ncy;
   logic [DIST_W+1:0]  sum_x, sum_y;
   logic [DIST_W:0]    rem_sh;
   logic [DIST_W-1:0]  q_sat, corr_v;
   logic [H_W-1:0]     half_h;
   logic [ASTEP_W+COL_W+1:0] sub_prod;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_column  = rsp_col_ff;
   assign rsp_ch.wall_top    = rsp_top_ff;
   assign rsp_ch.wall_bottom = rsp_bot_ff;
   assign rsp_ch.wall_hit    = rsp_hit_ff;
   assign rsp_ch.hit_side    = rsp_side_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         half_fov_ff   <= HALF_FOV_RST;
         angle_step_ff <= ANGLE_STEP_RST;
         plane_dist_ff <= PLANE_DIST_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HALF_FOV:   half_fov_ff   <= csr_wdata[FOV_W-1:0];
            CSR_ANGLE_STEP: angle_step_ff <= csr_wdata[ASTEP_W-1:0];
            CSR_PLANE_DIST: plane_dist_ff <= csr_wdata[PDIST_W-1:0];
            default: ;
         endcase
      end
   end

   // Wall map: one write port (clear sweep or map item), one registered read
   always_comb begin
      map_we    = 1'b0;
      map_waddr = clr_addr_ff;
      map_wdata = 1'b0;
      if (state_ff == ST_CLEAR) begin
         map_we = 1'b1;
      end else if (req_fire && req_ch.operation == OP_WRITE) begin
         map_we    = 1'b1;
         map_waddr = req_ch.cell_index[MAP_W-1:0];
         map_wdata = (req_ch.cell_value != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (map_we) map_mem[map_waddr] <= map_wdata;
      map_q_ff <= map_mem[map_raddr];
   end

   // Sine table port: fold the angle into the first quadrant
   always_comb begin
      priority case (state_ff)
         ST_TRIG_C: rom_ang = ray_ff + ANGLE_W'(QUARTER);
         ST_TRIG_S: rom_ang = ray_ff;
         default:   rom_ang = rel_ff + ANGLE_W'(QUARTER);
      endcase
      if (rom_ang[ANGLE_W-2])
         rom_idx = QIDX_W'(QUARTER) - QIDX_W'(rom_ang[ANGLE_W-3:0]);
      else
         rom_idx = QIDX_W'(rom_ang[ANGLE_W-3:0]);
   end

   always_ff @(posedge clock) begin
      rom_q_ff   <= SIN_ROM[rom_idx];
      rom_neg_ff <= rom_ang[ANGLE_W-1];
   end

   // Walk decision and shared divider step
   assign in_grid = (cx_ff < COORD_W'(GRID_CELLS)) && (cy_ff < COORD_W'(GRID_CELLS));
   assign c_pos   = (cmag_ff != '0) && !cneg_ff;
   assign s_pos   = (smag_ff != '0) && !sneg_ff;
   assign x_step  = (dx_ff <= dy_ff);
   assign ncx     = xdec_ff ? cx_ff - 1'b1 : cx_ff + 1'b1;
   assign ncy     = ydec_ff ? cy_ff - 1'b1 : cy_ff + 1'b1;
   assign out_ok  = x_step ? (ncx < COORD_W'(GRID_CELLS)) : (ncy < COORD_W'(GRID_CELLS));
   assign sum_x   = {1'b0, dx_ff} + (DIST_W+2)'(delx_ff);
   assign sum_y   = {1'b0, dy_ff} + (DIST_W+2)'(dely_ff);
   assign map_raddr = x_step ? {cy_ff[CELL_W-1:0], ncx[CELL_W-1:0]}
                             : {ncy[CELL_W-1:0], cx_ff[CELL_W-1:0]};
   assign rem_sh  = {rem_ff[DIST_W-1:0], num_ff[NUM_W-1]};
   assign q_sat   = (num_ff[NUM_W-1:DIST_W] != '0) ? DIST_SAT : num_ff[DIST_W-1:0];
   assign corr_v  = prod_ff[DIST_W+13:14];
   assign half_h  = h_ff >> 1;
   assign sub_prod = (ASTEP_W+COL_W+2)'((COL_W+1)'(req_ch.column) + 1'b1) *
                     (ASTEP_W+COL_W+2)'(angle_step_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (clr_addr_ff == MAP_W'(MAP_SIZE - 1)) state_in = ST_IDLE;
         ST_IDLE:   if (req_fire && req_ch.operation == OP_CAST) state_in = ST_TRIG_C;
         ST_TRIG_C: state_in = ST_TRIG_S;
         ST_TRIG_S: state_in = ST_TRIG_R;
         ST_TRIG_R: state_in = ST_SETUP;
         ST_SETUP: begin
            if (cmag_ff != '0 && smag_ff != '0) state_in = ST_DIV_LOAD;
            else if (in_grid)                   state_in = ST_WALK;
            else                                state_in = ST_DONE;
         end
         ST_DIV_LOAD: state_in = ST_DIV_RUN;
         ST_DIV_RUN:  if (cnt_ff == DCNT_W'(NUM_W - 1)) state_in = ST_DIV_STORE;
         ST_DIV_STORE: begin
            priority if (sel_ff == DIV_H)    state_in = ST_HEIGHT;
            else if (sel_ff != DIV_DELY)     state_in = ST_DIV_LOAD;
            else if (in_grid)                state_in = ST_WALK;
            else                             state_in = ST_DONE;
         end
         ST_WALK:     state_in = out_ok ? ST_WALK_CHK : ST_DONE;
         ST_WALK_CHK: state_in = map_q_ff ? ST_MULT : ST_WALK;
         ST_MULT:     state_in = ST_CORR;
         ST_CORR: begin
            if (rmag_ff == '0 || rneg_ff || corr_v == '0) state_in = ST_DONE;
            else                                          state_in = ST_DIV_LOAD;
         end
         ST_HEIGHT: state_in = ST_DONE;
         ST_DONE:   if (!rsp_valid_ff || rsp_ch.ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath updates
   always_comb begin
      sel_in = sel_ff;   clr_addr_in = clr_addr_ff;
      col_in = col_ff;   ray_in = ray_ff;   rel_in = rel_ff;
      cx_in = cx_ff;     cy_in = cy_ff;     vxo_in = vxo_ff;  vyo_in = vyo_ff;
      cmag_in = cmag_ff; cneg_in = cneg_ff; smag_in = smag_ff; sneg_in = sneg_ff;
      rmag_in = rmag_ff; rneg_in = rneg_ff;
      offx_in = offx_ff; offy_in = offy_ff; xdec_in = xdec_ff; ydec_in = ydec_ff;
      dx_in = dx_ff; dy_in = dy_ff; delx_in = delx_ff; dely_in = dely_ff;
      dist_in = dist_ff; corr_in = corr_ff; prod_in = prod_ff; h_in = h_ff;
      num_in = num_ff; den_in = den_ff; rem_in = rem_ff; cnt_in = cnt_ff;
      top_in = top_ff; bot_in = bot_ff; hit_in = hit_ff; side_in = side_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_col_in = rsp_col_ff; rsp_top_in = rsp_top_ff; rsp_bot_in = rsp_bot_ff;
      rsp_hit_in = rsp_hit_ff; rsp_side_in = rsp_side_ff;

      unique case (state_ff)
         ST_CLEAR: clr_addr_in = clr_addr_ff + 1'b1;
         ST_IDLE: begin
            // latch the cast and form the ray angle
            col_in  = req_ch.column;
            ray_in  = req_ch.view_angle + ANGLE_W'(half_fov_ff) - sub_prod[ANGLE_W-1:0];
            rel_in  = req_ch.view_angle - ray_in;
            cx_in   = COORD_W'(req_ch.view_x >> CELL_SHIFT);
            cy_in   = COORD_W'(req_ch.view_y >> CELL_SHIFT);
            vxo_in  = req_ch.view_x[CELL_SHIFT-1:0];
            vyo_in  = req_ch.view_y[CELL_SHIFT-1:0];
            hit_in  = 1'b0;
            side_in = 1'b0;
            top_in  = ROW_W'(HALF_ROWS);
            bot_in  = ROW_W'(HALF_ROWS);
         end
         ST_TRIG_C: ;
         ST_TRIG_S: begin
            cmag_in = rom_q_ff;
            cneg_in = rom_neg_ff;
         end
         ST_TRIG_R: begin
            smag_in = rom_q_ff;
            sneg_in = rom_neg_ff;
         end
         ST_SETUP: begin
            rmag_in = rom_q_ff;
            rneg_in = rom_neg_ff;
            xdec_in = !c_pos;
            ydec_in = s_pos;
            offx_in = c_pos ? OFF_W'(CELL_SPAN) - OFF_W'(vxo_ff) : OFF_W'(vxo_ff);
            offy_in = s_pos ? OFF_W'(vyo_ff) : OFF_W'(CELL_SPAN) - OFF_W'(vyo_ff);
            sel_in  = DIV_DX;
            // axis rays step one axis only
            if (cmag_ff == '0) begin
               dx_in   = DIST_INF;
               delx_in = '0;
               dy_in   = (DIST_W+1)'(offy_in) << 16;
               dely_in = DIST_W'(CELL_SPAN) << 16;
            end else if (smag_ff == '0) begin
               dy_in   = DIST_INF;
               dely_in = '0;
               dx_in   = (DIST_W+1)'(offx_in) << 16;
               delx_in = DIST_W'(CELL_SPAN) << 16;
            end
         end
         ST_DIV_LOAD: begin
            rem_in = '0;
            cnt_in = '0;
            unique case (sel_ff)
               DIV_DX: begin
                  num_in = NUM_W'(offx_ff) << 30;
                  den_in = DIST_W'(cmag_ff);
               end
               DIV_DELX: begin
                  num_in = NUM_W'(CELL_SPAN) << 30;
                  den_in = DIST_W'(cmag_ff);
               end
               DIV_DY: begin
                  num_in = NUM_W'(offy_ff) << 30;
                  den_in = DIST_W'(smag_ff);
               end
               DIV_DELY: begin
                  num_in = NUM_W'(CELL_SPAN) << 30;
                  den_in = DIST_W'(smag_ff);
               end
               default: begin
                  num_in = (NUM_W'(CELL_SPAN) * NUM_W'(plane_dist_ff)) << 16;
                  den_in = corr_ff;
               end
            endcase
         end
         ST_DIV_RUN: begin
            // one restoring step: shift a numerator bit in, try the subtract
            cnt_in = cnt_ff + 1'b1;
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in = rem_sh - {1'b0, den_ff};
               num_in = {num_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               num_in = {num_ff[NUM_W-2:0], 1'b0};
            end
         end
         ST_DIV_STORE: begin
            unique case (sel_ff)
               DIV_DX:   begin dx_in = {1'b0, q_sat}; sel_in = DIV_DELX; end
               DIV_DELX: begin delx_in = q_sat;     sel_in = DIV_DY;   end
               DIV_DY:   begin dy_in = {1'b0, q_sat}; sel_in = DIV_DELY; end
               DIV_DELY: dely_in = q_sat;
               default:  h_in = (num_ff > NUM_W'(H_MAX)) ? H_W'(H_MAX) : num_ff[H_W-1:0];
            endcase
         end
         ST_WALK: begin
            // advance one cell along the nearer boundary
            if (out_ok) begin
               if (x_step) begin
                  cx_in   = ncx;
                  dist_in = dx_ff[DIST_W-1:0];
                  dx_in   = (sum_x[DIST_W+1:DIST_W] != '0) ? {1'b0, DIST_SAT}
                                                           : sum_x[DIST_W:0];
                  side_in = 1'b1;
               end else begin
                  cy_in   = ncy;
                  dist_in = dy_ff[DIST_W-1:0];
                  dy_in   = (sum_y[DIST_W+1:DIST_W] != '0) ? {1'b0, DIST_SAT}
                                                           : sum_y[DIST_W:0];
                  side_in = 1'b0;
               end
            end else begin
               side_in = 1'b0;
            end
         end
         ST_WALK_CHK: if (map_q_ff) hit_in = 1'b1;
         ST_MULT: prod_in = PROD_W'(dist_ff) * PROD_W'(rmag_ff);
         ST_CORR: begin
            corr_in = corr_v;
            sel_in  = DIV_H;
            top_in  = '0;
            bot_in  = ROW_W'(SCREEN_ROWS);
         end
         ST_HEIGHT: begin
            top_in = (half_h > H_W'(HALF_ROWS)) ? '0 : ROW_W'(H_W'(HALF_ROWS) - half_h);
            bot_in = (half_h > H_W'(HALF_ROWS)) ? ROW_W'(SCREEN_ROWS)
                                                : ROW_W'(H_W'(HALF_ROWS) + half_h);
         end
         ST_DONE: begin
            // hand the result to the output register once it is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_col_in   = col_ff;
               rsp_top_in   = top_ff;
               rsp_bot_in   = bot_ff;
               rsp_hit_in   = hit_ff;
               rsp_side_in  = hit_ff && side_ff;
            end
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         sel_ff       <= DIV_DX;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         sel_ff       <= sel_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      col_ff <= col_in;   ray_ff <= ray_in;   rel_ff <= rel_in;
      cx_ff <= cx_in;     cy_ff <= cy_in;     vxo_ff <= vxo_in;  vyo_ff <= vyo_in;
      cmag_ff <= cmag_in; cneg_ff <= cneg_in; smag_ff <= smag_in; sneg_ff <= sneg_in;
      rmag_ff <= rmag_in; rneg_ff <= rneg_in;
      offx_ff <= offx_in; offy_ff <= offy_in; xdec_ff <= xdec_in; ydec_ff <= ydec_in;
      dx_ff <= dx_in; dy_ff <= dy_in; delx_ff <= delx_in; dely_ff <= dely_in;
      dist_ff <= dist_in; corr_ff <= corr_in; prod_ff <= prod_in; h_ff <= h_in;
      num_ff <= num_in; den_ff <= den_in; rem_ff <= rem_in; cnt_ff <= cnt_in;
      top_ff <= top_in; bot_ff <= bot_in; hit_ff <= hit_in; side_ff <= side_in;
      rsp_col_ff <= rsp_col_in; rsp_top_ff <= rsp_top_in; rsp_bot_ff <= rsp_bot_in;
      rsp_hit_ff <= rsp_hit_in; rsp_side_ff <= rsp_side_in;
   end

`include "grid_raycast_column_top_macros.svh"

   `GRC_ASSERT_IMPL(a_no_accept_in_clear, state_ff == ST_CLEAR, !req_ch.ready, "item taken during map clear")
   `GRC_ASSERT_NEXT(a_cast_starts, req_fire && req_ch.operation == OP_CAST, state_ff == ST_TRIG_C, "cast did not start")
   `GRC_ASSERT_IMPL(a_miss_mid_screen, rsp_ch.valid && !rsp_ch.wall_hit, rsp_ch.wall_top == rsp_ch.wall_bottom && !rsp_ch.hit_side, "miss result not at mid-screen")

endmodule
